// File: sv/lrsh_pkg.sv
// Package with the shared types, widths, codes and reset values of the rung selector.
`timescale 1ns / 1ps

package lrsh_pkg;

   localparam int unsigned RADIUS_W    = 21;
   localparam int unsigned DISTANCE_W  = 64;
   localparam int unsigned STAR_W      = 31;
   localparam int unsigned THRESH_W    = 20;
   localparam int unsigned RATIO_W     = 16;
   localparam int unsigned MARGIN_W    = 16;
   localparam int unsigned HOLD_W      = 8;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 20;

   // Signed width of a shifted radius boundary and of a shifted glint ratio.
   localparam int unsigned BOUND_W     = 22;
   localparam int unsigned SRATIO_W    = 18;
   localparam int unsigned PRODUCT_W   = SRATIO_W + STAR_W + 1;

   localparam logic [THRESH_W-1:0] DISC_THRESHOLD_RST   = THRESH_W'(1536);
   localparam logic [THRESH_W-1:0] CORONA_THRESHOLD_RST = THRESH_W'(384);
   localparam logic [RATIO_W-1:0]  GLINT_RATIO_RST      = RATIO_W'(1550);
   localparam logic [MARGIN_W-1:0] DISC_MARGIN_RST      = MARGIN_W'(154);
   localparam logic [MARGIN_W-1:0] CORONA_MARGIN_RST    = MARGIN_W'(38);
   localparam logic [MARGIN_W-1:0] GLINT_MARGIN_RST     = MARGIN_W'(155);
   localparam logic [HOLD_W-1:0]   HOLD_TICKS_RST       = HOLD_W'(15);
   localparam logic [HOLD_W-1:0]   HOLD_MAX             = HOLD_W'(255);

   typedef enum logic [1:0] {
      RUNG_DISC   = 2'd0,
      RUNG_CORONA = 2'd1,
      RUNG_GLINT  = 2'd2,
      RUNG_POINT  = 2'd3
   } rung_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DISC_THRESHOLD   = 3'd0,
      CSR_CORONA_THRESHOLD = 3'd1,
      CSR_GLINT_RATIO      = 3'd2,
      CSR_DISC_MARGIN      = 3'd3,
      CSR_CORONA_MARGIN    = 3'd4,
      CSR_GLINT_MARGIN     = 3'd5,
      CSR_HOLD_TICKS       = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [THRESH_W-1:0] disc_threshold;
      logic [THRESH_W-1:0] corona_threshold;
      logic [RATIO_W-1:0]  glint_ratio;
      logic [MARGIN_W-1:0] disc_margin;
      logic [MARGIN_W-1:0] corona_margin;
      logic [MARGIN_W-1:0] glint_margin;
      logic [HOLD_W-1:0]   hold_ticks;
   } cfg_type;

endpackage

// File: sv/lrsh_req_if.sv
// Interface of the request channel that carries one star per transaction.
`timescale 1ns / 1ps

interface lrsh_req_if;
   logic                                        valid;
   logic                                        ready;
   logic signed [lrsh_pkg::RADIUS_W-1:0]        proj_radius;
   logic signed [lrsh_pkg::DISTANCE_W-1:0]      distance;
   logic        [lrsh_pkg::STAR_W-1:0]          star_radius;

   modport source (output valid, proj_radius, distance, star_radius, input ready);
   modport sink   (input valid, proj_radius, distance, star_radius, output ready);
endinterface

// File: sv/lrsh_rsp_if.sv
// Interface of the response channel that carries the selected rung.
`timescale 1ns / 1ps

interface lrsh_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] rung;

   modport source (output valid, rung, input ready);
   modport sink   (input valid, rung, output ready);
endinterface

// File: sv/lrsh_csr.sv
// Configuration register file of the rung selector.
`timescale 1ns / 1ps

module lrsh_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lrsh_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lrsh_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output lrsh_pkg::cfg_type                   cfg
);

   lrsh_pkg::cfg_type cfg_ff;
   lrsh_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (lrsh_pkg::csr_index_type'(csr_index))
            lrsh_pkg::CSR_DISC_THRESHOLD: begin
               cfg_in.disc_threshold = csr_wdata[lrsh_pkg::THRESH_W-1:0];
            end
            lrsh_pkg::CSR_CORONA_THRESHOLD: begin
               cfg_in.corona_threshold = csr_wdata[lrsh_pkg::THRESH_W-1:0];
            end
            lrsh_pkg::CSR_GLINT_RATIO: begin
               cfg_in.glint_ratio = csr_wdata[lrsh_pkg::RATIO_W-1:0];
            end
            lrsh_pkg::CSR_DISC_MARGIN: begin
               cfg_in.disc_margin = csr_wdata[lrsh_pkg::MARGIN_W-1:0];
            end
            lrsh_pkg::CSR_CORONA_MARGIN: begin
               cfg_in.corona_margin = csr_wdata[lrsh_pkg::MARGIN_W-1:0];
            end
            lrsh_pkg::CSR_GLINT_MARGIN: begin
               cfg_in.glint_margin = csr_wdata[lrsh_pkg::MARGIN_W-1:0];
            end
            lrsh_pkg::CSR_HOLD_TICKS: begin
               cfg_in.hold_ticks = csr_wdata[lrsh_pkg::HOLD_W-1:0];
            end
            default: begin
               // Unmapped index: the write is dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.disc_threshold   <= lrsh_pkg::DISC_THRESHOLD_RST;
         cfg_ff.corona_threshold <= lrsh_pkg::CORONA_THRESHOLD_RST;
         cfg_ff.glint_ratio      <= lrsh_pkg::GLINT_RATIO_RST;
         cfg_ff.disc_margin      <= lrsh_pkg::DISC_MARGIN_RST;
         cfg_ff.corona_margin    <= lrsh_pkg::CORONA_MARGIN_RST;
         cfg_ff.glint_margin     <= lrsh_pkg::GLINT_MARGIN_RST;
         cfg_ff.hold_ticks       <= lrsh_pkg::HOLD_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/lrsh_classify.sv
// Boundary shifting and candidate rung classification for one star.
`timescale 1ns / 1ps

module lrsh_classify (
   input  lrsh_pkg::cfg_type                       cfg,
   input  logic                                    started,
   input  lrsh_pkg::rung_type                      current_rung,
   input  logic signed [lrsh_pkg::RADIUS_W-1:0]    proj_radius,
   input  logic signed [lrsh_pkg::DISTANCE_W-1:0]  distance,
   input  logic        [lrsh_pkg::STAR_W-1:0]      star_radius,
   output lrsh_pkg::rung_type                      cand_rung
);

   localparam int unsigned BW = lrsh_pkg::BOUND_W;
   localparam int unsigned RW = lrsh_pkg::SRATIO_W;
   localparam int unsigned PW = lrsh_pkg::PRODUCT_W;
   localparam int unsigned DW = lrsh_pkg::DISTANCE_W;

   logic signed [BW-1:0] radius_s;
   logic signed [BW-1:0] disc_thr_s;
   logic signed [BW-1:0] corona_thr_s;
   logic signed [BW-1:0] disc_mrg_s;
   logic signed [BW-1:0] corona_mrg_s;
   logic signed [BW-1:0] disc_bound;
   logic signed [BW-1:0] corona_bound;
   logic signed [RW-1:0] ratio_s;
   logic signed [RW-1:0] glint_mrg_s;
   logic signed [RW-1:0] ratio_bound;
   logic signed [lrsh_pkg::STAR_W:0] star_s;
   logic signed [PW-1:0] product;
   logic signed [DW-1:0] product_ext;

   always_comb begin
      radius_s     = {proj_radius[lrsh_pkg::RADIUS_W-1], proj_radius};
      disc_thr_s   = $signed({{(BW-lrsh_pkg::THRESH_W){1'b0}}, cfg.disc_threshold});
      corona_thr_s = $signed({{(BW-lrsh_pkg::THRESH_W){1'b0}}, cfg.corona_threshold});
      ratio_s      = $signed({{(RW-lrsh_pkg::RATIO_W){1'b0}}, cfg.glint_ratio});

      // The very first star sees the raw boundaries.
      if (started) begin
         disc_mrg_s   = $signed({{(BW-lrsh_pkg::MARGIN_W){1'b0}}, cfg.disc_margin});
         corona_mrg_s = $signed({{(BW-lrsh_pkg::MARGIN_W){1'b0}}, cfg.corona_margin});
         glint_mrg_s  = $signed({{(RW-lrsh_pkg::MARGIN_W){1'b0}}, cfg.glint_margin});
      end else begin
         disc_mrg_s   = '0;
         corona_mrg_s = '0;
         glint_mrg_s  = '0;
      end

      // Each boundary moves away from the rung currently shown.
      if (current_rung == lrsh_pkg::RUNG_DISC) begin
         disc_bound = disc_thr_s - disc_mrg_s;
      end else begin
         disc_bound = disc_thr_s + disc_mrg_s;
      end
      if (current_rung == lrsh_pkg::RUNG_DISC || current_rung == lrsh_pkg::RUNG_CORONA) begin
         corona_bound = corona_thr_s - corona_mrg_s;
      end else begin
         corona_bound = corona_thr_s + corona_mrg_s;
      end
      if (current_rung == lrsh_pkg::RUNG_POINT) begin
         ratio_bound = ratio_s - glint_mrg_s;
      end else begin
         ratio_bound = ratio_s + glint_mrg_s;
      end

      star_s      = $signed({1'b0, star_radius});
      product     = PW'(ratio_bound) * PW'(star_s);
      product_ext = {{(DW-PW){product[PW-1]}}, product};

      if (radius_s >= disc_bound) begin
         cand_rung = lrsh_pkg::RUNG_DISC;
      end else if (radius_s >= corona_bound) begin
         cand_rung = lrsh_pkg::RUNG_CORONA;
      end else if (distance <= product_ext) begin
         cand_rung = lrsh_pkg::RUNG_GLINT;
      end else begin
         cand_rung = lrsh_pkg::RUNG_POINT;
      end
   end

endmodule

// File: sv/lod_rung_select_hysteresis_top.sv
// Top level of the level-of-detail rung selector with hysteresis and hold counter.
`timescale 1ns / 1ps

// Usage
// The request channel (req_chan) takes one star per transaction: its projected
// radius in signed S12.8 pixels, its viewer distance and its physical radius.
// The response channel (rsp_chan) returns exactly one rung per request, in
// order: 0 disc, 1 corona, 2 glint, 3 point.
// Configuration registers are written through csr_we, csr_index and csr_wdata,
// one register per cycle with no wait; writes to an unmapped index are dropped.
// Write them only while no request is in flight.
// An accepted request is loaded into the input register; when it moves on, the
// classify logic and the state update land together in the rung register,
// which is also the response register. Throughput is one transaction per
// cycle while the receiver does not stall; the limit is the single rung and
// hold-count update per cycle that each star needs from the one before it.
// When the receiver stalls, the finished response waits in the rung register
// and one more request may still be taken into the input register; after that
// req_chan.ready drops until the response is taken.
// Synchronous reset clears both stages, restores all configuration registers to their
// default values and marks the selector as not yet started, so the first
// star after reset is classified against the unshifted boundaries.

module lod_rung_select_hysteresis_top (
   input  logic                              clock,
   input  logic                              reset,
   lrsh_req_if.sink                          req_chan,
   lrsh_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [lrsh_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lrsh_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   lrsh_pkg::cfg_type  cfg;
   lrsh_pkg::rung_type cand_rung;

   // Input stage.
   logic                                        s1_valid_ff;
   logic                                        s1_valid_in;
   logic signed [lrsh_pkg::RADIUS_W-1:0]        s1_radius_ff;
   logic signed [lrsh_pkg::DISTANCE_W-1:0]      s1_distance_ff;
   logic        [lrsh_pkg::STAR_W-1:0]          s1_star_ff;

   // Selector state; rung_ff doubles as the response register.
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic                         started_ff;
   logic                         started_in;
   lrsh_pkg::rung_type           rung_ff;
   lrsh_pkg::rung_type           rung_in;
   logic [lrsh_pkg::HOLD_W-1:0]  hold_ff;
   logic [lrsh_pkg::HOLD_W-1:0]  hold_in;

   logic req_take;
   logic advance;

   lrsh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lrsh_classify u_classify (
      .cfg          (cfg),
      .started      (started_ff),
      .current_rung (rung_ff),
      .proj_radius  (s1_radius_ff),
      .distance     (s1_distance_ff),
      .star_radius  (s1_star_ff),
      .cand_rung    (cand_rung)
   );

   // A star moves out of the input stage when the response register is free
   // or is being emptied in this same cycle.
   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);
      started_in   = started_ff;
      rung_in      = rung_ff;
      hold_in      = hold_ff;
      if (advance) begin
         if (!started_ff) begin
            // First star: take the raw classification and start counting.
            started_in = 1'b1;
            rung_in    = cand_rung;
            hold_in    = '0;
         end else if (cand_rung != rung_ff && hold_ff >= cfg.hold_ticks) begin
            rung_in = cand_rung;
            hold_in = '0;
         end else if (hold_ff < lrsh_pkg::HOLD_MAX) begin
            hold_in = hold_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
         rung_ff      <= lrsh_pkg::RUNG_DISC;
         hold_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         started_ff   <= started_in;
         rung_ff      <= rung_in;
         hold_ff      <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_radius_ff   <= req_chan.proj_radius;
         s1_distance_ff <= req_chan.distance;
         s1_star_ff     <= req_chan.star_radius;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.rung  = rung_ff;

   // A star leaving the input stage always produces a response next cycle.
   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced transaction did not reach the response register");

   // An empty input stage must always be able to take a request.
   a_empty_is_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_chan.ready)
      else $error("input stage empty but request channel not ready");

   // Before the first star the hold counter stays cleared.
   a_idle_hold_clear: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> hold_ff == '0)
      else $error("hold counter moved before the first transaction");

   // Once started, a rung change always restarts the hold counter.
   a_change_clears_hold: assert property (@(posedge clock) disable iff (reset)
      (advance && started_ff && cand_rung != rung_ff && hold_ff >= cfg.hold_ticks)
         |=> hold_ff == '0)
      else $error("rung changed without clearing the hold counter");

   // The rung never changes without a transaction passing through.
   a_rung_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(rung_ff))
      else $error("rung changed without a transaction");

endmodule
